// ===== rtl/ddpi_pkg.sv =====
// Package for the differential-drive pose integrator.
// Holds constants, the sequencer state type and the CORDIC arctangent table.
// No dependencies.
package ddpi_pkg;

    localparam int CMD_GAIN_DEF     = 15;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_LEN         = 24;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 24;

    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_RADIUS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_OFFSET = 2'd3;

    localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;
    localparam logic signed [31:0] BAU_PER_RAD_Q16 = 32'sd683565276;

    typedef enum logic [4:0] {
        S_IDLE,
        S_WL_GAIN, S_WL_ACC, S_WL_DAMP, S_WL_SAT,
        S_WR_GAIN, S_WR_ACC, S_WR_DAMP, S_WR_SAT,
        S_LIN, S_ANG_MUL, S_DIV, S_ANG_FIN,
        S_CORDIC, S_VX_MUL, S_VX_FIN, S_VY_MUL, S_VY_FIN,
        S_HD_MUL, S_HD_FIN, S_PX_MUL, S_PX_FIN, S_PY_MUL, S_PY_FIN,
        S_OUT
    } t_state;

    // Arctangent of 2^-i in 32-bit binary angle units.
    function automatic logic [31:0] atan_lut(input logic [4:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
                5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
                5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
                5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
                5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
                5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
                5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
                5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
                5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
                5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
                5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
                5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction

    // Saturate a 64-bit signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        begin
            if (v > 64'sh000000007FFFFFFF) r = 32'sh7FFFFFFF;
            else if (v < -64'sh0000000080000000) r = 32'sh80000000;
            else r = v[31:0];
            return r;
        end
    endfunction

    // Shift right with rounding to nearest, halves away from zero.
    function automatic logic signed [63:0] shr_round(input logic signed [63:0] v,
                                                     input logic [5:0] s);
        logic [63:0] m;
        logic        neg;
        begin
            neg = v[63];
            m = neg ? (64'd0 - v) : v;
            m = (m + (64'd1 << (s - 6'd1))) >> s;
            return neg ? -$signed(m) : $signed(m);
        end
    endfunction

endpackage

// ===== rtl/diff_drive_pose_integrator.sv =====
// Top level of the differential-drive pose integrator.
// Uses ddpi_pkg and the serial divider ddpi_div.
//
// Channel   Dir  Payload
// s_axis    in   tdata[1:0] left_cmd, tdata[3:2] right_cmd
// m_axis    out  tdata: pos_x, pos_y, heading, linear_speed, angular_speed (144 bits)
// config    in   i_cfg_we, i_cfg_idx, i_cfg_data
//
// The 64-step serial divider and the CORDIC iterations over the one shift-add
// unit set the time per item. A single 33x33 multiplier is shared by all
// products. The input is not ready until the result has been taken from the
// output register. Reset clears the state and loads the register defaults.
module diff_drive_pose_integrator #(
    parameter int CMD_GAIN     = ddpi_pkg::CMD_GAIN_DEF,
    parameter int CORDIC_STEPS = ddpi_pkg::CORDIC_STEPS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // left_cmd, right_cmd
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // pos_x, pos_y, heading, linear_speed, angular_speed
    output logic [143:0]                    m_axis_tdata,
    input  logic                            i_cfg_we,
    input  logic [ddpi_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ddpi_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    localparam int STEPS = (CORDIC_STEPS < ddpi_pkg::ATAN_LEN) ? CORDIC_STEPS
                                                               : ddpi_pkg::ATAN_LEN;

    ddpi_pkg::t_state r_state, n_state;

    logic [15:0] r_time_step, r_damping;
    logic [23:0] r_wheel_radius, r_wheel_offset;
    logic signed [31:0] r_left, r_right, r_px, r_py, r_lin, r_ang, r_vx, r_vy;
    logic [15:0] r_head;
    logic signed [2:0] r_lc, r_rc;
    logic signed [63:0] r_acc;
    logic signed [31:0] r_v;
    logic signed [32:0] r_cx, r_cy;
    logic signed [33:0] r_cz;
    logic [4:0]  r_it;
    logic        r_flip;
    logic        r_neg;
    logic        r_oval;

    // Shared multiplier operands.
    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] w_prod;
    assign w_prod = w_ma * w_mb;

    logic        w_div_start, w_div_done;
    logic [63:0] w_div_num, w_quot;
    logic [23:0] w_off;
    logic signed [63:0] w_diff;
    assign w_off  = (r_wheel_offset == '0) ? 24'd1 : r_wheel_offset;
    assign w_diff = r_acc;
    assign w_div_num = w_diff[63] ? (64'd0 - w_diff) : w_diff;

    ddpi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_off),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Multiplier operand selection per sequencer step.
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            ddpi_pkg::S_WL_GAIN: begin
                w_ma = 33'(signed'(r_lc) * CMD_GAIN);
                w_mb = $signed({17'd0, r_time_step});
            end
            ddpi_pkg::S_WR_GAIN: begin
                w_ma = 33'(signed'(r_rc) * CMD_GAIN);
                w_mb = $signed({17'd0, r_time_step});
            end
            ddpi_pkg::S_WL_ACC, ddpi_pkg::S_WR_ACC: begin
                w_ma = r_acc[32:0];
                w_mb = $signed({9'd0, r_wheel_radius});
            end
            ddpi_pkg::S_WL_DAMP, ddpi_pkg::S_WR_DAMP: begin
                w_ma = {r_v[31], r_v};
                w_mb = $signed(33'(17'h10000 - {1'b0, r_damping}));
            end
            ddpi_pkg::S_ANG_MUL: begin
                w_ma = {r_right[31], r_right} - {r_left[31], r_left};
                w_mb = {1'b0, ddpi_pkg::BAU_PER_RAD_Q16};
            end
            ddpi_pkg::S_VX_MUL: begin
                w_ma = {r_lin[31], r_lin};
                w_mb = r_flip ? -r_cy : r_cy;
            end
            ddpi_pkg::S_VY_MUL: begin
                w_ma = {r_lin[31], r_lin};
                w_mb = r_flip ? -r_cx : r_cx;
            end
            ddpi_pkg::S_HD_MUL: begin
                w_ma = {r_ang[31], r_ang};
                w_mb = $signed({17'd0, r_time_step});
            end
            ddpi_pkg::S_PX_MUL: begin
                w_ma = {r_vx[31], r_vx};
                w_mb = $signed({17'd0, r_time_step});
            end
            ddpi_pkg::S_PY_MUL: begin
                w_ma = {r_vy[31], r_vy};
                w_mb = $signed({17'd0, r_time_step});
            end
            default: ;
        endcase
    end

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        w_div_start = 1'b0;
        unique case (r_state)
            ddpi_pkg::S_IDLE:    if (s_axis_tvalid && s_axis_tready)
                                     n_state = ddpi_pkg::S_WL_GAIN;
            ddpi_pkg::S_WL_GAIN: n_state = ddpi_pkg::S_WL_ACC;
            ddpi_pkg::S_WL_ACC:  n_state = ddpi_pkg::S_WL_DAMP;
            ddpi_pkg::S_WL_DAMP: n_state = ddpi_pkg::S_WL_SAT;
            ddpi_pkg::S_WL_SAT:  n_state = ddpi_pkg::S_WR_GAIN;
            ddpi_pkg::S_WR_GAIN: n_state = ddpi_pkg::S_WR_ACC;
            ddpi_pkg::S_WR_ACC:  n_state = ddpi_pkg::S_WR_DAMP;
            ddpi_pkg::S_WR_DAMP: n_state = ddpi_pkg::S_WR_SAT;
            ddpi_pkg::S_WR_SAT:  n_state = ddpi_pkg::S_LIN;
            ddpi_pkg::S_LIN:     n_state = ddpi_pkg::S_ANG_MUL;
            ddpi_pkg::S_ANG_MUL: n_state = ddpi_pkg::S_DIV;
            ddpi_pkg::S_DIV: begin
                w_div_start = 1'b1;
                n_state = ddpi_pkg::S_ANG_FIN;
            end
            ddpi_pkg::S_ANG_FIN: if (w_div_done) n_state = ddpi_pkg::S_CORDIC;
            ddpi_pkg::S_CORDIC:  if (r_it == 5'(STEPS - 1)) n_state = ddpi_pkg::S_VX_MUL;
            ddpi_pkg::S_VX_MUL:  n_state = ddpi_pkg::S_VX_FIN;
            ddpi_pkg::S_VX_FIN:  n_state = ddpi_pkg::S_VY_MUL;
            ddpi_pkg::S_VY_MUL:  n_state = ddpi_pkg::S_VY_FIN;
            ddpi_pkg::S_VY_FIN:  n_state = ddpi_pkg::S_HD_MUL;
            ddpi_pkg::S_HD_MUL:  n_state = ddpi_pkg::S_HD_FIN;
            ddpi_pkg::S_HD_FIN:  n_state = ddpi_pkg::S_PX_MUL;
            ddpi_pkg::S_PX_MUL:  n_state = ddpi_pkg::S_PX_FIN;
            ddpi_pkg::S_PX_FIN:  n_state = ddpi_pkg::S_PY_MUL;
            ddpi_pkg::S_PY_MUL:  n_state = ddpi_pkg::S_PY_FIN;
            ddpi_pkg::S_PY_FIN:  n_state = ddpi_pkg::S_OUT;
            ddpi_pkg::S_OUT:     if (!r_oval) n_state = ddpi_pkg::S_IDLE;
            default:             n_state = ddpi_pkg::S_IDLE;
        endcase
    end

    assign s_axis_tready = (r_state == ddpi_pkg::S_IDLE) && !r_oval;

    // CORDIC step values.
    logic signed [32:0] w_dx, w_dy;
    assign w_dx = r_cy >>> r_it;
    assign w_dy = r_cx >>> r_it;

    logic [31:0] w_ang32;
    logic [1:0]  w_quad;
    assign w_ang32 = {r_head, 16'd0};
    assign w_quad  = w_ang32[31:30];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ddpi_pkg::S_IDLE;
            r_time_step    <= 16'd1092;
            r_wheel_radius <= 24'd3277;
            r_damping      <= 16'd655;
            r_wheel_offset <= 24'd13107;
            r_left  <= '0;
            r_right <= '0;
            r_px    <= '0;
            r_py    <= '0;
            r_head  <= '0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            // Configuration writes.
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    ddpi_pkg::REG_TIME_STEP:    r_time_step    <= i_cfg_data[15:0];
                    ddpi_pkg::REG_WHEEL_RADIUS: r_wheel_radius <= i_cfg_data;
                    ddpi_pkg::REG_DAMPING:      r_damping      <= i_cfg_data[15:0];
                    ddpi_pkg::REG_WHEEL_OFFSET: r_wheel_offset <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_oval && m_axis_tready) r_oval <= 1'b0;

            unique case (r_state)
                ddpi_pkg::S_IDLE: begin
                    r_lc <= {s_axis_tdata[1], s_axis_tdata[1:0]};
                    r_rc <= {s_axis_tdata[3], s_axis_tdata[3:2]};
                end
                ddpi_pkg::S_WL_GAIN, ddpi_pkg::S_WR_GAIN: r_acc <= 64'(w_prod);
                ddpi_pkg::S_WL_ACC:
                    r_v <= ddpi_pkg::sat32(64'(r_left) +
                           ddpi_pkg::shr_round(64'(w_prod), 6'd16));
                ddpi_pkg::S_WR_ACC:
                    r_v <= ddpi_pkg::sat32(64'(r_right) +
                           ddpi_pkg::shr_round(64'(w_prod), 6'd16));
                ddpi_pkg::S_WL_DAMP, ddpi_pkg::S_WR_DAMP: r_acc <= 64'(w_prod);
                ddpi_pkg::S_WL_SAT:
                    r_left <= ddpi_pkg::sat32(ddpi_pkg::shr_round(r_acc, 6'd16));
                ddpi_pkg::S_WR_SAT:
                    r_right <= ddpi_pkg::sat32(ddpi_pkg::shr_round(r_acc, 6'd16));
                ddpi_pkg::S_LIN: begin
                    logic signed [32:0] s;
                    s = 33'(r_right) + 33'(r_left);
                    r_lin <= 32'((s + (s[32] ? 33'sd1 : 33'sd0)) >>> 1);
                end
                ddpi_pkg::S_ANG_MUL: begin
                    r_acc <= 64'(w_prod);
                    r_neg <= w_prod[65];
                end
                ddpi_pkg::S_ANG_FIN: begin
                    // Set up the CORDIC rotation while the divider finishes.
                    r_flip <= (w_quad == 2'd1) || (w_quad == 2'd2);
                    r_cx <= 33'(ddpi_pkg::CORDIC_GAIN_Q30);
                    r_cy <= '0;
                    r_cz <= ((w_quad == 2'd1) || (w_quad == 2'd2)) ?
                            34'($signed(w_ang32 + 32'h80000000)) : 34'($signed(w_ang32));
                    r_it <= '0;
                    if (w_div_done)
                        r_ang <= ddpi_pkg::sat32(r_neg ? -$signed(w_quot) : $signed(w_quot));
                end
                ddpi_pkg::S_CORDIC: begin
                    if (!r_cz[33]) begin
                        r_cx <= r_cx - w_dx;
                        r_cy <= r_cy + w_dy;
                        r_cz <= r_cz - 34'(ddpi_pkg::atan_lut(r_it));
                    end else begin
                        r_cx <= r_cx + w_dx;
                        r_cy <= r_cy - w_dy;
                        r_cz <= r_cz + 34'(ddpi_pkg::atan_lut(r_it));
                    end
                    r_it <= r_it + 5'd1;
                end
                ddpi_pkg::S_VX_MUL, ddpi_pkg::S_VY_MUL, ddpi_pkg::S_HD_MUL,
                ddpi_pkg::S_PX_MUL, ddpi_pkg::S_PY_MUL: r_acc <= 64'(w_prod);
                ddpi_pkg::S_VX_FIN:
                    r_vx <= ddpi_pkg::sat32(ddpi_pkg::shr_round(r_acc, 6'd30));
                ddpi_pkg::S_VY_FIN:
                    r_vy <= ddpi_pkg::sat32(-ddpi_pkg::shr_round(r_acc, 6'd30));
                ddpi_pkg::S_HD_FIN: begin
                    logic signed [63:0] inc;
                    inc = ddpi_pkg::shr_round(r_acc, 6'd32);
                    r_head <= r_head + inc[15:0];
                end
                ddpi_pkg::S_PX_FIN:
                    r_px <= ddpi_pkg::sat32(64'(r_px) + ddpi_pkg::shr_round(r_acc, 6'd16));
                ddpi_pkg::S_PY_FIN: begin
                    r_py <= ddpi_pkg::sat32(64'(r_py) + ddpi_pkg::shr_round(r_acc, 6'd16));
                    r_oval <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // The pose and speed registers hold still until the next item is accepted,
    // which cannot happen before the result has been taken.
    assign m_axis_tvalid = r_oval && (r_state == ddpi_pkg::S_OUT);
    assign m_axis_tdata  = {r_ang, r_lin, r_head, r_py, r_px};
endmodule

// ===== rtl/ddpi_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, unsigned.
// Used for the angular speed; depends on nothing but its ports.
module ddpi_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [23:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quot
);
    logic [63:0] r_q;
    logic [24:0] r_rem;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [24:0] w_sh;
    logic        w_ge;

    // One restoring step on the shifted partial remainder.
    assign w_sh = {r_rem[23:0], r_q[63]};
    assign w_ge = w_sh >= {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
                r_q    <= i_num;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= w_ge ? (w_sh - {1'b0, i_den}) : w_sh;
                r_q   <= {r_q[62:0], w_ge};
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = r_q;
endmodule

// ===== dv/diff_drive_pose_integrator_test.sv =====
// Testbench for the differential-drive pose integrator.
// Drives tick commands over the input stream and checks every output item against
// a cycle-free predictor of the wheel, CORDIC and integration math, or a typed-in expectation. Uses ddpi_pkg.
`timescale 1ns / 100ps

module diff_drive_pose_integrator_test;

    localparam int MAX_CYCLES = 400000;

    // Tick output as seen on the master stream.
    typedef struct packed {
        logic signed [31:0] ang;
        logic signed [31:0] lin;
        logic [15:0]        hdg;
        logic signed [31:0] py;
        logic signed [31:0] px;
    } t_pose;

    // Directed row: commands, and an optional typed-in expectation.
    typedef struct {
        logic [1:0] lc;
        logic [1:0] rc;
        bit         fixed;
        t_pose      exp_pose;
    } t_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [143:0] m_axis_tdata;
    logic         i_cfg_we;
    logic [ddpi_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [ddpi_pkg::CFG_DATA_W-1:0] i_cfg_data;

    diff_drive_pose_integrator u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // Predictor copy of configuration and state.
    logic [15:0] m_dt;
    logic [23:0] m_radius;
    logic [15:0] m_damp;
    logic [23:0] m_offset;
    logic signed [31:0] m_vl, m_vr, m_x, m_y;
    logic [15:0] m_hdg;

    t_pose  pending_poses[$];
    int     n_fail = 0;
    int     n_seen = 0;
    longint cycles = 0;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint round_shift(longint v, int s);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (64'sd1 <<< (s - 1))) >>> s;
        return (v < 0) ? -m : m;
    endfunction

    function automatic longint drive_wheel(longint v, longint cmd);
        longint acc, nv;
        acc = cmd * ddpi_pkg::CMD_GAIN_DEF * longint'(m_dt) * longint'(m_radius);
        nv = clamp32(v + round_shift(acc, 16));
        return clamp32(round_shift(nv * (65536 - longint'(m_damp)), 16));
    endfunction

    // Sine and cosine of the heading in Q1.30.
    task automatic heading_sincos(input logic [15:0] h, output longint sn,
                                  output longint cs);
        logic [31:0] a;
        bit flip;
        longint x, y, z, dx, dy;
        a = {h, 16'h0};
        flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
        if (flip) a = a + 32'h80000000;
        x = ddpi_pkg::CORDIC_GAIN_Q30;
        y = 0;
        z = longint'($signed(a));
        for (int i = 0; i < ddpi_pkg::CORDIC_STEPS_DEF && i < ddpi_pkg::ATAN_LEN; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ddpi_pkg::atan_lut(5'(i)));
            end else begin
                x += dx; y -= dy; z += longint'(ddpi_pkg::atan_lut(5'(i)));
            end
        end
        sn = flip ? -y : y;
        cs = flip ? -x : x;
    endtask

    // Advance the predicted pose by one tick.
    task automatic predict_tick(input logic [1:0] lc, input logic [1:0] rc,
                                output t_pose p);
        longint l, r, lin, ang, sn, cs, vx, vy, inc, off, m;
        l = longint'($signed(lc));
        r = longint'($signed(rc));
        off = (m_offset == 0) ? 1 : longint'(m_offset);
        m_vl = 32'(drive_wheel(m_vl, l));
        m_vr = 32'(drive_wheel(m_vr, r));
        lin = (longint'(m_vr) + longint'(m_vl)) / 2;
        m = (longint'(m_vr) - longint'(m_vl)) * longint'(ddpi_pkg::BAU_PER_RAD_Q16);
        ang = clamp32((m < 0) ? -((-m) / off) : m / off);
        heading_sincos(m_hdg, sn, cs);
        vx = clamp32(round_shift(lin * sn, 30));
        vy = clamp32(-round_shift(lin * cs, 30));
        inc = round_shift(ang * longint'(m_dt), 32);
        m_hdg = m_hdg + inc[15:0];
        m_x = 32'(clamp32(longint'(m_x) + round_shift(vx * longint'(m_dt), 16)));
        m_y = 32'(clamp32(longint'(m_y) + round_shift(vy * longint'(m_dt), 16)));
        p.px = m_x; p.py = m_y; p.hdg = m_hdg;
        p.lin = lin[31:0]; p.ang = ang[31:0];
    endtask

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Timeout guard.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Output side: random wait per item, compare each item with the oldest expectation.
    initial begin
        t_pose got, want;
        int    wait_cycles;
        m_axis_tready = 0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            wait_cycles = $urandom_range(0, 17);
            if (wait_cycles != 0) begin
                m_axis_tready <= 1'b0;
                repeat (wait_cycles) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            got = t_pose'(m_axis_tdata);
            n_seen++;
            if (pending_poses.size() == 0) begin
                $error("output item with no expectation");
                n_fail++;
            end else begin
                want = pending_poses.pop_front();
                if (got.px !== want.px) begin
                    $error("pos_x exp %0d got %0d", want.px, got.px); n_fail++;
                end
                if (got.py !== want.py) begin
                    $error("pos_y exp %0d got %0d", want.py, got.py); n_fail++;
                end
                if (got.hdg !== want.hdg) begin
                    $error("heading exp %0d got %0d", want.hdg, got.hdg); n_fail++;
                end
                if (got.lin !== want.lin) begin
                    $error("linear_speed exp %0d got %0d", want.lin, got.lin); n_fail++;
                end
                if (got.ang !== want.ang) begin
                    $error("angular_speed exp %0d got %0d", want.ang, got.ang); n_fail++;
                end
            end
            @(negedge i_clk);
        end
    end

    task automatic write_reg(input logic [ddpi_pkg::CFG_IDX_W-1:0] idx,
                             input logic [23:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
        case (idx)
            ddpi_pkg::REG_TIME_STEP:    m_dt = val[15:0];
            ddpi_pkg::REG_WHEEL_RADIUS: m_radius = val;
            ddpi_pkg::REG_DAMPING:      m_damp = val[15:0];
            ddpi_pkg::REG_WHEEL_OFFSET: m_offset = val;
            default: ;
        endcase
    endtask

    // Send one tick and queue its expected pose.
    task automatic send_tick(input logic [1:0] lc, input logic [1:0] rc,
                             input bit fixed, input t_pose fixed_pose);
        t_pose p;
        int    wait_cycles;
        wait_cycles = $urandom_range(0, 17);
        if (wait_cycles != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (wait_cycles) @(negedge i_clk);
        end
        s_axis_tdata <= {4'h0, rc, lc};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_tick(lc, rc, p);
        pending_poses.push_back(fixed ? fixed_pose : p);
        @(negedge i_clk);
    endtask

    // Stop sending and wait until every expected result has come.
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending_poses.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic clear_state;
        m_vl = 0; m_vr = 0; m_x = 0; m_y = 0; m_hdg = 0;
    endtask

    task automatic random_cmd(output logic [1:0] c);
        int k;
        k = $urandom_range(0, 15);
        c = (k == 0) ? 2'b10 : (k < 6) ? 2'b01 : (k < 10) ? 2'b11 : 2'b00;
    endtask

    initial begin
        t_row rows[$];
        t_row row;
        t_pose zero_pose;
        logic [1:0] lc, rc;
        zero_pose = '0;
        i_rst_n = 0; s_axis_tvalid = 0; s_axis_tdata = 0;
        i_cfg_we = 0; i_cfg_idx = 0; i_cfg_data = 0;
        m_dt = 1092; m_radius = 3277; m_damp = 655; m_offset = 13107;
        clear_state();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed rows: idle after reset is all zero, then each command pattern.
        row = '{2'b00, 2'b00, 1, zero_pose}; rows.push_back(row);
        row = '{2'b00, 2'b00, 1, zero_pose}; rows.push_back(row);
        for (int l = 0; l < 4; l++)
            for (int r = 0; r < 4; r++) begin
                row = '{l[1:0], r[1:0], 0, zero_pose}; rows.push_back(row);
            end
        // Spin in place for six ticks to turn the heading.
        for (int i = 0; i < 6; i++) begin
            row = '{2'b11, 2'b01, 0, zero_pose}; rows.push_back(row);
        end
        foreach (rows[i]) send_tick(rows[i].lc, rows[i].rc, rows[i].fixed, rows[i].exp_pose);
        drain();

        // Random phases over several register settings, extremes included.
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: begin
                    write_reg(ddpi_pkg::REG_TIME_STEP, 24'hFFFF);
                    write_reg(ddpi_pkg::REG_WHEEL_RADIUS, 24'hFFFFFF);
                    write_reg(ddpi_pkg::REG_DAMPING, 24'h0);
                    write_reg(ddpi_pkg::REG_WHEEL_OFFSET, 24'h0);
                end
                1: begin
                    write_reg(ddpi_pkg::REG_TIME_STEP, 24'h0);
                    write_reg(ddpi_pkg::REG_WHEEL_RADIUS, 24'h0);
                    write_reg(ddpi_pkg::REG_DAMPING, 24'hFFFF);
                    write_reg(ddpi_pkg::REG_WHEEL_OFFSET, 24'hFFFFFF);
                end
                2: begin
                    write_reg(ddpi_pkg::REG_TIME_STEP, 24'd1092);
                    write_reg(ddpi_pkg::REG_WHEEL_RADIUS, 24'd3277);
                    write_reg(ddpi_pkg::REG_DAMPING, 24'd655);
                    write_reg(ddpi_pkg::REG_WHEEL_OFFSET, 24'd1);
                end
                default: begin
                    write_reg(ddpi_pkg::REG_TIME_STEP, 24'($urandom_range(0, 65535)));
                    write_reg(ddpi_pkg::REG_WHEEL_RADIUS, 24'($urandom_range(0, 24'hFFFFFF)));
                    write_reg(ddpi_pkg::REG_DAMPING, 24'($urandom_range(0, 65535)));
                    write_reg(ddpi_pkg::REG_WHEEL_OFFSET, 24'($urandom_range(0, 24'hFFFFFF)));
                end
            endcase
            for (int i = 0; i < 48; i++) begin
                random_cmd(lc);
                random_cmd(rc);
                send_tick(lc, rc, 0, zero_pose);
            end
            drain();
        end

        $display("Covered %0d output items over directed command patterns and ten", n_seen);
        $display("register settings including zero, full-scale and zero-offset cases.");
        if (n_fail == 0 && pending_poses.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/ddpi_pkg.sv
rtl/ddpi_div.sv
rtl/diff_drive_pose_integrator.sv
dv/diff_drive_pose_integrator_test.sv
